### rtl/rsbk_pkg.sv
// ----------------------------------------------------------------------------
// rsbk_pkg
// Types and constants shared by the record sorter: item and result layouts,
// the stored record and the sequencer states.
// ----------------------------------------------------------------------------
package rsbk_pkg;

  localparam int PAYLOAD_W = 48;
  localparam int KEY_W     = 48;

  // one input item: a record and its end-of-set mark
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [KEY_W-1:0]     sort_key;
    logic                 last_in;
  } rec_in_t;

  // one result item: a record in sorted position
  typedef struct packed {
    logic [PAYLOAD_W-1:0] out_payload;
    logic [KEY_W-1:0]     out_key;
    logic                 last_out;
    logic                 overflowed;
  } rec_out_t;

  // one entry of the record store
  typedef struct packed {
    logic [PAYLOAD_W-1:0] payload;
    logic [KEY_W-1:0]     key;
  } record_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

endpackage

### rtl/record_sorter_by_key_top.sv
// ----------------------------------------------------------------------------
// record_sorter_by_key_top
// Collects records and emits each set sorted by key, stable on equal keys.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on item and are taken when start is high and busy is
//   low. While a set is being loaded busy stays low, so one record per cycle
//   can be written into the store. Records beyond MAX_RECORDS are dropped and
//   every result of that set carries overflowed.
//   An item with last_in set closes the set: busy rises and the block emits
//   the n stored records on result, each marked by a one-cycle done strobe,
//   in ascending key order; last_out marks the final one. The receiver cannot
//   stall; results must be taken when done is high.
//   Sorting is by repeated selection through two (key, index) comparators:
//   each result costs a full scan of the store over its single read port
//   (the reads, the registered read data, then one emit state). After the
//   last result of a set busy falls and the next set can load.
//   Reset (rst, synchronous) empties the set and returns to idle; the store
//   contents are not cleared, since only written entries are ever read.
// ----------------------------------------------------------------------------
module record_sorter_by_key_top #(
  parameter int MAX_RECORDS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  rsbk_pkg::rec_in_t  item,
  output logic               done,
  output rsbk_pkg::rec_out_t result
);
  import rsbk_pkg::*;

  localparam int AW    = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int CW    = $clog2(MAX_RECORDS + 1);
  localparam int CAT_W = KEY_W + AW;
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_RECORDS);

  state_t            state;
  logic [CW-1:0]     count;
  logic              drop_flag;
  logic [AW-1:0]     scan_idx;
  logic              issuing;
  logic              rd_valid;
  logic [AW-1:0]     rd_idx;
  logic [AW-1:0]     out_cnt;
  logic              have_last;
  logic [CAT_W-1:0]  last_cat;
  logic              best_valid;
  logic [CAT_W-1:0]  best_cat;
  logic [PAYLOAD_W-1:0] best_payload;

  logic              accept;
  logic              store_we;
  record_t           wr_rec;
  record_t           rd_rec;
  logic [CW-1:0]     count_m1;
  logic [AW-1:0]     last_idx;
  logic [CAT_W-1:0]  cand_cat;
  logic              cand_ok;
  logic              cand_better;

  assign accept   = start && (state == ST_IDLE);
  assign store_we = accept && (count != FULL_COUNT);
  assign wr_rec   = '{payload: item.payload, key: item.sort_key};
  assign count_m1 = count - CW'(1);
  assign last_idx = count_m1[AW-1:0];

  rsbk_mem #(
    .DEPTH (MAX_RECORDS)
  ) u_mem (
    .clk   (clk),
    .we    (store_we),
    .waddr (count[AW-1:0]),
    .wdata (wr_rec),
    .re    (issuing),
    .raddr (scan_idx),
    .rdata (rd_rec)
  );

  // shared compare unit: (key, index) above the last emitted and below the best
  assign cand_cat    = {rd_rec.key, rd_idx};
  assign cand_ok     = !have_last || (cand_cat > last_cat);
  assign cand_better = !best_valid || (cand_cat < best_cat);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      drop_flag  <= 1'b0;
      issuing    <= 1'b0;
      rd_valid   <= 1'b0;
      have_last  <= 1'b0;
      best_valid <= 1'b0;
      scan_idx   <= '0;
      out_cnt    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (store_we) begin
              count <= count + CW'(1);
            end else begin
              drop_flag <= 1'b1;
            end
            if (item.last_in) begin
              state      <= ST_SCAN;
              scan_idx   <= '0;
              issuing    <= 1'b1;
              rd_valid   <= 1'b0;
              out_cnt    <= '0;
              have_last  <= 1'b0;
              best_valid <= 1'b0;
            end
          end
        end
        ST_SCAN: begin
          if (issuing) begin
            if (scan_idx == last_idx) begin
              issuing <= 1'b0;
            end else begin
              scan_idx <= scan_idx + AW'(1);
            end
          end
          rd_valid <= issuing;
          rd_idx   <= scan_idx;
          if (rd_valid) begin
            if (cand_ok && cand_better) begin
              best_valid <= 1'b1;
            end
            if (rd_idx == last_idx) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          rd_valid <= 1'b0;
          if (out_cnt == last_idx) begin
            state     <= ST_IDLE;
            count     <= '0;
            drop_flag <= 1'b0;
            have_last <= 1'b0;
          end else begin
            state      <= ST_SCAN;
            out_cnt    <= out_cnt + AW'(1);
            have_last  <= 1'b1;
            scan_idx   <= '0;
            issuing    <= 1'b1;
            best_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // best candidate and last emitted position
  always_ff @(posedge clk) begin
    if (state == ST_SCAN && rd_valid && cand_ok && cand_better) begin
      best_cat     <= cand_cat;
      best_payload <= rd_rec.payload;
    end
    if (state == ST_EMIT) begin
      last_cat <= best_cat;
    end
  end

  // result port
  assign busy                = (state != ST_IDLE);
  assign done                = (state == ST_EMIT);
  assign result.out_payload  = best_payload;
  assign result.out_key      = best_cat[CAT_W-1:AW];
  assign result.last_out     = (out_cnt == last_idx);
  assign result.overflowed   = drop_flag;

endmodule

### rtl/rsbk_mem.sv
// ----------------------------------------------------------------------------
// rsbk_mem
// Record store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rsbk_mem #(
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  rsbk_pkg::record_t wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output rsbk_pkg::record_t rdata
);
  import rsbk_pkg::*;

  record_t mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
